/* hw/rtl/mma_pkg.sv */
// ----------------------------------------------------------------------------
// mma_pkg
// types, codes and constants of the montgomery multiply-accumulate block
// ----------------------------------------------------------------------------
package mma_pkg;

  localparam int unsigned COEF_W    = 32;
  localparam int unsigned ACC_W     = 2 * COEF_W;
  localparam int unsigned MODULUS_W = 31;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned MUL_W     = COEF_W + 1;

  localparam logic [MODULUS_W-1:0] MODULUS_RST     = 31'd8380417;
  localparam logic [COEF_W-1:0]    MODULUS_INV_RST = 32'd58728449;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODULUS     = 1'b0,
    CFG_MODULUS_INV = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_PROD,
    OP_ACC,
    OP_MINV,
    OP_MQ,
    OP_SUB
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic last_term;
  } sts_t;

endpackage

/* hw/rtl/mma_in_if.sv */
// ----------------------------------------------------------------------------
// mma_in_if
// input word channel: coefficient pair and last-term flag
// ----------------------------------------------------------------------------
interface mma_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [mma_pkg::COEF_W-1:0]   coef_a;
  logic signed [mma_pkg::COEF_W-1:0]   coef_b;
  logic                                last_term;

  modport source (output valid, output coef_a, output coef_b, output last_term,
                  input ready);
  modport sink   (input valid, input coef_a, input coef_b, input last_term,
                  output ready);
endinterface

/* hw/rtl/mma_out_if.sv */
// ----------------------------------------------------------------------------
// mma_out_if
// output word channel: reduced result
// ----------------------------------------------------------------------------
interface mma_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mma_pkg::COEF_W-1:0]   reduced;

  modport source (output valid, output reduced, input ready);
  modport sink   (input valid, input reduced, output ready);
endinterface

/* hw/rtl/mma_ctrl.sv */
// ----------------------------------------------------------------------------
// mma_ctrl
// sequencer for the shared multiplier: product, accumulate, reduction steps
// ----------------------------------------------------------------------------
module mma_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  mma_pkg::sts_t         sts_i,
  output mma_pkg::cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROD,
    S_ACC,
    S_MINV,
    S_MQ,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o.op    = mma_pkg::OP_NONE;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = mma_pkg::OP_LOAD;
          state_d  = S_PROD;
        end
      end
      S_PROD: begin
        cmd_o.op = mma_pkg::OP_PROD;
        state_d  = S_ACC;
      end
      S_ACC: begin
        cmd_o.op = mma_pkg::OP_ACC;
        state_d  = sts_i.last_term ? S_MINV : S_IDLE;
      end
      S_MINV: begin
        cmd_o.op = mma_pkg::OP_MINV;
        state_d  = S_MQ;
      end
      S_MQ: begin
        cmd_o.op = mma_pkg::OP_MQ;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.op    = mma_pkg::OP_SUB;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* hw/rtl/mma_datapath.sv */
// ----------------------------------------------------------------------------
// mma_datapath
// operand registers, shared 33x33 multiplier, accumulator and config registers
// ----------------------------------------------------------------------------
module mma_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mma_pkg::cmd_t                       cmd_i,
  output mma_pkg::sts_t                       sts_o,
  input  logic signed [mma_pkg::COEF_W-1:0]   coef_a_i,
  input  logic signed [mma_pkg::COEF_W-1:0]   coef_b_i,
  input  logic                                last_term_i,
  input  logic                                cfg_we_i,
  input  logic [mma_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mma_pkg::CFG_W-1:0]           cfg_data_i,
  output logic signed [mma_pkg::COEF_W-1:0]   reduced_o
);

  logic signed [mma_pkg::COEF_W-1:0]    a_q, b_q;
  logic                                 last_q;
  logic [mma_pkg::ACC_W-1:0]            acc_q;
  logic [mma_pkg::ACC_W-1:0]            prod_q;
  logic [mma_pkg::COEF_W-1:0]           m_q;
  logic [mma_pkg::COEF_W-1:0]           out_q;
  logic [mma_pkg::MODULUS_W-1:0]        mod_q;
  logic [mma_pkg::COEF_W-1:0]           minv_q;

  logic signed [mma_pkg::MUL_W-1:0]     mul_x, mul_y;
  logic signed [2*mma_pkg::MUL_W-1:0]   mul_full;
  logic [mma_pkg::ACC_W-1:0]            diff;

  always_comb begin
    case (cmd_i.op)
      mma_pkg::OP_MINV: begin
        mul_x = {1'b0, acc_q[mma_pkg::COEF_W-1:0]};
        mul_y = {1'b0, minv_q};
      end
      mma_pkg::OP_MQ: begin
        mul_x = {m_q[mma_pkg::COEF_W-1], m_q};
        mul_y = {2'b00, mod_q};
      end
      default: begin
        mul_x = {a_q[mma_pkg::COEF_W-1], a_q};
        mul_y = {b_q[mma_pkg::COEF_W-1], b_q};
      end
    endcase
  end

  assign mul_full = mul_x * mul_y;
  assign diff     = acc_q - prod_q;

  // operand and product registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      mma_pkg::OP_LOAD: begin
        a_q    <= coef_a_i;
        b_q    <= coef_b_i;
        last_q <= last_term_i;
      end
      mma_pkg::OP_PROD: prod_q <= mul_full[mma_pkg::ACC_W-1:0];
      mma_pkg::OP_MINV: m_q    <= mul_full[mma_pkg::COEF_W-1:0];
      mma_pkg::OP_MQ:   prod_q <= mul_full[mma_pkg::ACC_W-1:0];
      mma_pkg::OP_SUB:  out_q  <= diff[mma_pkg::ACC_W-1:mma_pkg::COEF_W];
      default: begin
      end
    endcase
  end

  // accumulator and config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      mod_q  <= mma_pkg::MODULUS_RST;
      minv_q <= mma_pkg::MODULUS_INV_RST;
    end else begin
      if (cmd_i.op == mma_pkg::OP_ACC) begin
        acc_q <= acc_q + prod_q;
      end else if (cmd_i.op == mma_pkg::OP_SUB) begin
        acc_q <= '0;
      end
      if (cfg_we_i) begin
        case (mma_pkg::cfg_idx_e'(cfg_idx_i))
          mma_pkg::CFG_MODULUS:     mod_q  <= cfg_data_i[mma_pkg::MODULUS_W-1:0];
          mma_pkg::CFG_MODULUS_INV: minv_q <= cfg_data_i[mma_pkg::COEF_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  assign sts_o.last_term = last_q;
  assign reduced_o       = out_q;

endmodule

/* hw/rtl/montgomery_multiply_accumulate_top.sv */
// ----------------------------------------------------------------------------
// montgomery_multiply_accumulate_top
// signed 32-bit multiply-accumulate with montgomery reduction on the last term
// ----------------------------------------------------------------------------
// channel   direction  contents
// in_i      sink       coef_a, coef_b, last_term
// out_o     source     reduced
// cfg       write      cfg_we_i, cfg_idx_i, cfg_data_i (modulus, modulus inverse)
//
// every word is multiplied and accumulated, a last word also reduced: one shared
// 33x33 multiplier is used in turn for the product and both reduction multiplies
// reset clears the accumulator and loads the default modulus and its inverse
// the result sits in an output register; a new word is taken while it waits,
// and the next result holds in the sequencer until that register is free
// ----------------------------------------------------------------------------
module montgomery_multiply_accumulate_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  mma_in_if.sink                          in_i,
  mma_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [mma_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mma_pkg::CFG_W-1:0]       cfg_data_i
);

  mma_pkg::cmd_t cmd;
  mma_pkg::sts_t sts;

  mma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mma_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .coef_a_i    (in_i.coef_a),
    .coef_b_i    (in_i.coef_b),
    .last_term_i (in_i.last_term),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .reduced_o   (out_o.reduced)
  );

endmodule

/* hw/rtl/mma_checker.sv */
// ----------------------------------------------------------------------------
// mma_checker
// port-level checks of the multiply-accumulate block, bound to the top level
// ----------------------------------------------------------------------------
module mma_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                in_last,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [mma_pkg::COEF_W-1:0]   out_reduced
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_reduced))
    else $error("output word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready)
    else $error("input ready right after an accepted word");

  a_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a reduction in progress");

  a_no_result_mid_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !in_last |=> !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("result produced for a word without last_term");

endmodule

bind montgomery_multiply_accumulate_top mma_checker u_mma_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_i.valid),
  .in_ready    (in_i.ready),
  .in_last     (in_i.last_term),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .out_reduced (out_o.reduced)
);
